// ===== rtl/itdd_pkg.sv =====
// Shared types and constants of the fixed-width decimal text formatter.
`default_nettype none

package itdd_pkg;

   localparam int NUMBER_W = 31;
   localparam int COUNT_W = 4;
   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int DIGIT_W = 4;
   localparam int BITS_W = $clog2(NUMBER_W);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DEF_MAX_DIGITS = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_CODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARK_CODE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE = 2'd3;

   localparam logic [CHAR_W-1:0] RESET_ZERO_CODE = 8'd161;
   localparam logic [CHAR_W-1:0] RESET_SPACE_CODE = 8'd0;
   localparam logic [CHAR_W-1:0] RESET_MARK_CODE = 8'd172;
   localparam logic [CHAR_W-1:0] RESET_END_CODE = 8'd255;

   localparam logic [MODE_W-1:0] MODE_LEFT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPACE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_ALIGN,
      ST_EMIT,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
      logic bit_in;
   } bcd_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/itdd_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
`default_nettype none

interface itdd_req_if;
   logic                               valid;
   logic                               ready;
   logic [itdd_pkg::NUMBER_W-1:0]      number;
   logic [itdd_pkg::COUNT_W-1:0]       digit_count;
   logic [itdd_pkg::MODE_W-1:0]        align_mode;

   modport source (output valid, output number, output digit_count, output align_mode,
                   input ready);
   modport sink (input valid, input number, input digit_count, input align_mode,
                 output ready);
endinterface

interface itdd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [itdd_pkg::CHAR_W-1:0]        char_out;
   logic                               last_char;

   modport source (output valid, output char_out, output last_char, input ready);
   modport sink (input valid, input char_out, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/itdd_dabble.sv =====
// BCD shift register: shift-and-add-3 conversion and digit-wise shift toward the top.
`default_nettype none

module itdd_dabble #(
   parameter int MAX_DIGITS = itdd_pkg::DEF_MAX_DIGITS
) (
   input  wire logic                          clock,
   input  wire itdd_pkg::bcd_ctl_type         ctl,
   output logic [itdd_pkg::DIGIT_W-1:0]       top_digit,
   output logic                               carry
);

   localparam int DW = MAX_DIGITS * itdd_pkg::DIGIT_W;

   logic [DW-1:0] bcd_ff;
   logic [DW-1:0] bcd_in;
   logic [DW-1:0] adj;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*itdd_pkg::DIGIT_W +: itdd_pkg::DIGIT_W] > 4'd4) begin
            adj[i*itdd_pkg::DIGIT_W +: itdd_pkg::DIGIT_W] =
               bcd_ff[i*itdd_pkg::DIGIT_W +: itdd_pkg::DIGIT_W] + 4'd3;
         end else begin
            adj[i*itdd_pkg::DIGIT_W +: itdd_pkg::DIGIT_W] =
               bcd_ff[i*itdd_pkg::DIGIT_W +: itdd_pkg::DIGIT_W];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      if (ctl.clear) begin
         bcd_in = '0;
      end else if (ctl.dabble) begin
         bcd_in = {adj[DW-2:0], ctl.bit_in};
      end else if (ctl.shift) begin
         bcd_in = bcd_ff << itdd_pkg::DIGIT_W;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign carry = adj[DW-1];
   assign top_digit = bcd_ff[DW-1 -: itdd_pkg::DIGIT_W];

endmodule

`default_nettype wire

// ===== rtl/int_to_decimal_digits.sv =====
// Top level of the fixed-width binary to decimal text formatter.
//
// Channel   Dir  Payload                              Transfer
// req_ch    in   number, digit_count, align_mode      valid && ready
// rsp_ch    out  char_out, last_char                  valid && ready
// csr_*     in   csr_index, csr_wdata                 csr_we
//
// An item passes through the request transfer, 31 shift-and-add-3 steps of the BCD
// register, one digit shift per position above the digit count, one emitted or skipped
// step per considered position and the terminator.
// A stalled response holds the sequencer in place. Reset is synchronous and loads the
// register defaults.
`default_nettype none

module int_to_decimal_digits #(
   parameter int MAX_DIGITS = itdd_pkg::DEF_MAX_DIGITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   itdd_req_if.sink                               req_ch,
   itdd_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [itdd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [itdd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   itdd_pkg::state_type state_ff, state_in;
   logic [itdd_pkg::NUMBER_W-1:0] num_ff, num_in;
   logic [itdd_pkg::BITS_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] level_ff, level_in;
   logic [itdd_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic ovf_ff, ovf_in;
   logic writing_ff, writing_in;
   logic [itdd_pkg::CHAR_W-1:0] zero_code_ff, space_code_ff, mark_code_ff, end_code_ff;

   itdd_pkg::bcd_ctl_type bcd_ctl;
   logic [itdd_pkg::DIGIT_W-1:0] top_digit;
   logic carry;
   logic [itdd_pkg::COUNT_W-1:0] count_req;
   logic show;
   logic show_writes;

   itdd_dabble #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_dabble (
      .clock(clock),
      .ctl(bcd_ctl),
      .top_digit(top_digit),
      .carry(carry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_code_ff <= itdd_pkg::RESET_ZERO_CODE;
         space_code_ff <= itdd_pkg::RESET_SPACE_CODE;
         mark_code_ff <= itdd_pkg::RESET_MARK_CODE;
         end_code_ff <= itdd_pkg::RESET_END_CODE;
      end else if (csr_we) begin
         case (csr_index)
            itdd_pkg::CSR_ZERO_CODE: zero_code_ff <= csr_wdata;
            itdd_pkg::CSR_SPACE_CODE: space_code_ff <= csr_wdata;
            itdd_pkg::CSR_MARK_CODE: mark_code_ff <= csr_wdata;
            itdd_pkg::CSR_END_CODE: end_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_ch.digit_count == '0) begin
         count_req = itdd_pkg::COUNT_W'(1);
      end else if (req_ch.digit_count > itdd_pkg::COUNT_W'(MAX_DIGITS)) begin
         count_req = itdd_pkg::COUNT_W'(MAX_DIGITS);
      end else begin
         count_req = req_ch.digit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itdd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      bits_ff <= bits_in;
      count_ff <= count_in;
      level_ff <= level_in;
      mode_ff <= mode_in;
      ovf_ff <= ovf_in;
      writing_ff <= writing_in;
   end

   always_comb begin
      state_in = state_ff;
      num_in = num_ff;
      bits_in = bits_ff;
      count_in = count_ff;
      level_in = level_ff;
      mode_in = mode_ff;
      ovf_in = ovf_ff;
      writing_in = writing_ff;
      bcd_ctl = '0;
      bcd_ctl.bit_in = num_ff[itdd_pkg::NUMBER_W-1];
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      rsp_ch.char_out = end_code_ff;
      rsp_ch.last_char = 1'b0;
      show = 1'b0;
      show_writes = 1'b0;

      case (state_ff)
         itdd_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               num_in = req_ch.number;
               count_in = CNT_W'(count_req);
               mode_in = req_ch.align_mode;
               bits_in = itdd_pkg::BITS_W'(itdd_pkg::NUMBER_W - 1);
               level_in = CNT_W'(MAX_DIGITS);
               ovf_in = 1'b0;
               writing_in = 1'b0;
               bcd_ctl.clear = 1'b1;
               state_in = itdd_pkg::ST_CONV;
            end
         end
         itdd_pkg::ST_CONV: begin
            bcd_ctl.dabble = 1'b1;
            num_in = num_ff << 1;
            if (carry) begin
               ovf_in = 1'b1;
            end
            if (bits_ff == '0) begin
               state_in = itdd_pkg::ST_ALIGN;
            end else begin
               bits_in = bits_ff - itdd_pkg::BITS_W'(1);
            end
         end
         itdd_pkg::ST_ALIGN: begin
            if (level_ff > count_ff) begin
               bcd_ctl.shift = 1'b1;
               level_in = level_ff - CNT_W'(1);
               if (top_digit != '0) begin
                  ovf_in = 1'b1;
               end
            end else begin
               state_in = itdd_pkg::ST_EMIT;
            end
         end
         itdd_pkg::ST_EMIT: begin
            if (level_ff == count_ff && ovf_ff) begin
               show = 1'b1;
               show_writes = 1'b1;
               rsp_ch.char_out = mark_code_ff;
            end else if (writing_ff || mode_ff == itdd_pkg::MODE_ZERO ||
                         top_digit != '0 || level_ff == CNT_W'(1)) begin
               show = 1'b1;
               show_writes = 1'b1;
               rsp_ch.char_out = zero_code_ff + {{(itdd_pkg::CHAR_W - itdd_pkg::DIGIT_W){1'b0}},
                                                 top_digit};
            end else if (mode_ff == itdd_pkg::MODE_SPACE) begin
               show = 1'b1;
               rsp_ch.char_out = space_code_ff;
            end
            rsp_ch.valid = show;
            if (!show || rsp_ch.ready) begin
               bcd_ctl.shift = 1'b1;
               level_in = level_ff - CNT_W'(1);
               if (show_writes) begin
                  writing_in = 1'b1;
               end
               if (level_ff == CNT_W'(1)) begin
                  state_in = itdd_pkg::ST_TERM;
               end
            end
         end
         itdd_pkg::ST_TERM: begin
            rsp_ch.valid = 1'b1;
            rsp_ch.char_out = end_code_ff;
            rsp_ch.last_char = 1'b1;
            if (rsp_ch.ready) begin
               state_in = itdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itdd_pkg::ST_IDLE;
         end
      endcase
   end

   // An accepted request always starts the conversion in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == itdd_pkg::ST_CONV))
      else $error("request transfer did not start the conversion");

   // While positions are emitted, the position counter stays within the digit count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == itdd_pkg::ST_EMIT) |-> (level_ff <= count_ff && level_ff != '0))
      else $error("position counter left the considered positions");

   // Below the leading position the BCD register holds only valid decimal digits.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == itdd_pkg::ST_EMIT && level_ff != count_ff) |->
         (top_digit <= itdd_pkg::DIGIT_MAX))
      else $error("lower position holds a digit above nine");

   // The terminator transfer ends the item and returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_char) |=>
         (state_ff == itdd_pkg::ST_IDLE))
      else $error("terminator transfer did not end the item");

endmodule

`default_nettype wire
